FILE: rtl/core/scsp_pkg.sv
package scsp_pkg;

  // fixed field widths of the set interface
  localparam int unsigned SCSP_WAYS      = 16;
  localparam int unsigned SCSP_SECTORS   = 8;
  localparam int unsigned SCSP_TAG_BITS  = 32;
  localparam int unsigned SCSP_ADDR_BITS = 48;
  localparam int unsigned SCSP_KIND_BITS = 4;

  // operation codes, unlisted codes behave as a lookup
  typedef enum logic [SCSP_KIND_BITS-1:0] {
    KIND_LOOKUP     = 4'd0,
    KIND_ACCESS     = 4'd1,
    KIND_INSERT     = 4'd2,
    KIND_EVICT      = 4'd3,
    KIND_VALIDATE   = 4'd4,
    KIND_INVALIDATE = 4'd5,
    KIND_BUSY       = 4'd6,
    KIND_IDLE       = 4'd7,
    KIND_SET_DIRTY  = 4'd8,
    KIND_ADD        = 4'd9
  } kind_e;

  typedef struct packed {
    logic [SCSP_KIND_BITS-1:0] kind;
    logic [SCSP_TAG_BITS-1:0]  tag;
    logic [SCSP_TAG_BITS-1:0]  new_tag;
    logic [SCSP_SECTORS-1:0]   sector_bits;
    logic                      is_write;
    logic [SCSP_ADDR_BITS-1:0] inst_addr;
  } in_t;

  typedef struct packed {
    logic                      found;
    logic                      block_valid;
    logic                      block_busy;
    logic                      block_dirty;
    logic [SCSP_SECTORS-1:0]   sector_valid_mask;
    logic [SCSP_SECTORS-1:0]   used_mask;
    logic [SCSP_SECTORS-1:0]   dirty_sector_mask;
    logic [SCSP_SECTORS-1:0]   missing_mask;
    logic                      victim_found;
    logic [SCSP_TAG_BITS-1:0]  victim_tag;
    logic                      free_way_exists;
    logic [SCSP_ADDR_BITS-1:0] stored_inst_addr;
  } out_t;

endpackage

FILE: rtl/core/sectored_cache_set_plru.sv
// path: an item passes through the input register, then the tag compare and state
// update into the result register, from which it transfers out
// throughput: 1 item per cycle unless the output stalls; the cycle is set by
// the parallel tag compare, first-match select and state update between the
// two registers
// reset: all way state and per-way bits clear, plru_enable 1, both registers empty
module sectored_cache_set_plru #(
  parameter int unsigned WAYS = scsp_pkg::SCSP_WAYS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  scsp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scsp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);
  import scsp_pkg::*;

  logic  in_valid_q;
  in_t   in_data_q;
  logic  out_valid_q;
  out_t  out_data_q;
  logic  plru_enable_q;
  logic  advance;
  out_t  result;
  logic [WAYS-1:0] hit;

  logic [WAYS-1:0][SCSP_TAG_BITS-1:0]  tags;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   present;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   used;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   written;
  logic [WAYS-1:0][SCSP_ADDR_BITS-1:0] addr;
  logic [WAYS-1:0] valid;
  logic [WAYS-1:0] busy;
  logic [WAYS-1:0] dirty;
  logic [WAYS-1:0] mru;

  // the held item moves on when the result register is free or being emptied
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plru_enable_q <= 1'b1;
    end else if (cfg_valid_i) begin
      plru_enable_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  scsp_lookup #(
    .WAYS(WAYS)
  ) u_lookup (
    .tag_i        (in_data_q.tag),
    .sector_bits_i(in_data_q.sector_bits),
    .plru_enable_i(plru_enable_q),
    .tags_i       (tags),
    .present_i    (present),
    .used_i       (used),
    .written_i    (written),
    .addr_i       (addr),
    .valid_i      (valid),
    .busy_i       (busy),
    .dirty_i      (dirty),
    .mru_i        (mru),
    .hit_o        (hit),
    .result_o     (result)
  );

  scsp_ways #(
    .WAYS(WAYS)
  ) u_ways (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .update_i     (advance),
    .op_i         (in_data_q),
    .hit_i        (hit),
    .plru_enable_i(plru_enable_q),
    .tags_o       (tags),
    .present_o    (present),
    .used_o       (used),
    .written_o    (written),
    .addr_o       (addr),
    .valid_o      (valid),
    .busy_o       (busy),
    .dirty_o      (dirty),
    .mru_o        (mru)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/scsp_lookup.sv
module scsp_lookup #(
  parameter int unsigned WAYS = scsp_pkg::SCSP_WAYS
) (
  input  logic [scsp_pkg::SCSP_TAG_BITS-1:0]             tag_i,
  input  logic [scsp_pkg::SCSP_SECTORS-1:0]              sector_bits_i,
  input  logic                                           plru_enable_i,
  input  logic [WAYS-1:0][scsp_pkg::SCSP_TAG_BITS-1:0]   tags_i,
  input  logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    present_i,
  input  logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    used_i,
  input  logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    written_i,
  input  logic [WAYS-1:0][scsp_pkg::SCSP_ADDR_BITS-1:0]  addr_i,
  input  logic [WAYS-1:0]                                valid_i,
  input  logic [WAYS-1:0]                                busy_i,
  input  logic [WAYS-1:0]                                dirty_i,
  input  logic [WAYS-1:0]                                mru_i,
  output logic [WAYS-1:0]                                hit_o,
  output scsp_pkg::out_t                                 result_o
);
  import scsp_pkg::*;

  logic [WAYS-1:0] tag_eq;
  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] not_mru;
  logic [WAYS-1:0] victim;

  // parallel tag compare, lowest matching way wins
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tag_eq[i] = (tags_i[i] == tag_i);
    end
  end
  assign hit     = tag_eq & (~tag_eq + WAYS'(1));
  assign not_mru = ~mru_i;
  assign victim  = not_mru & (~not_mru + WAYS'(1));
  assign hit_o   = hit;

  // one-hot selects of the matched and victim ways
  always_comb begin
    logic [SCSP_SECTORS-1:0]   pres;
    logic [SCSP_SECTORS-1:0]   used;
    logic [SCSP_SECTORS-1:0]   wrt;
    logic [SCSP_ADDR_BITS-1:0] addr;
    logic [SCSP_TAG_BITS-1:0]  vtag;
    pres = '0;
    used = '0;
    wrt  = '0;
    addr = '0;
    vtag = '0;
    for (int i = 0; i < WAYS; i++) begin
      pres = pres | (present_i[i] & {SCSP_SECTORS{hit[i]}});
      used = used | (used_i[i] & {SCSP_SECTORS{hit[i]}});
      wrt  = wrt | (written_i[i] & {SCSP_SECTORS{hit[i]}});
      addr = addr | (addr_i[i] & {SCSP_ADDR_BITS{hit[i]}});
      vtag = vtag | (tags_i[i] & {SCSP_TAG_BITS{victim[i]}});
    end
    result_o.found             = |tag_eq;
    result_o.block_valid       = |(valid_i & hit);
    result_o.block_busy        = |(busy_i & hit);
    result_o.block_dirty       = |(dirty_i & hit);
    result_o.sector_valid_mask = pres;
    result_o.used_mask         = used;
    result_o.dirty_sector_mask = wrt;
    result_o.missing_mask      = (|tag_eq) ? (sector_bits_i & ~pres) : '0;
    result_o.victim_found      = plru_enable_i & (|not_mru);
    result_o.victim_tag        = plru_enable_i ? vtag : '0;
    result_o.free_way_exists   = |(~valid_i);
    result_o.stored_inst_addr  = addr;
  end

endmodule

FILE: rtl/core/scsp_ways.sv
module scsp_ways #(
  parameter int unsigned WAYS = scsp_pkg::SCSP_WAYS
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           update_i,
  input  scsp_pkg::in_t                                  op_i,
  input  logic [WAYS-1:0]                                hit_i,
  input  logic                                           plru_enable_i,
  output logic [WAYS-1:0][scsp_pkg::SCSP_TAG_BITS-1:0]   tags_o,
  output logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    present_o,
  output logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    used_o,
  output logic [WAYS-1:0][scsp_pkg::SCSP_SECTORS-1:0]    written_o,
  output logic [WAYS-1:0][scsp_pkg::SCSP_ADDR_BITS-1:0]  addr_o,
  output logic [WAYS-1:0]                                valid_o,
  output logic [WAYS-1:0]                                busy_o,
  output logic [WAYS-1:0]                                dirty_o,
  output logic [WAYS-1:0]                                mru_o
);
  import scsp_pkg::*;

  logic [WAYS-1:0][SCSP_TAG_BITS-1:0]  tags_q, tags_d;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   present_q, present_d;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   used_q, used_d;
  logic [WAYS-1:0][SCSP_SECTORS-1:0]   written_q, written_d;
  logic [WAYS-1:0][SCSP_ADDR_BITS-1:0] addr_q, addr_d;
  logic [WAYS-1:0] valid_q, valid_d;
  logic [WAYS-1:0] busy_q, busy_d;
  logic [WAYS-1:0] dirty_q, dirty_d;
  logic [WAYS-1:0] mru_q, mru_d;
  logic [WAYS-1:0] mru_touched;
  logic [WAYS-1:0] mru_after_touch;
  logic [WAYS-1:0] sel;

  // only the matched way of a found tag changes
  assign sel = hit_i & {WAYS{update_i}};

  // mru touch: set the bit, and restart the round when all bits are set
  assign mru_touched     = mru_q | hit_i;
  assign mru_after_touch = (&mru_touched) ? hit_i : mru_touched;

  // per-way bit vectors
  always_comb begin
    valid_d = valid_q;
    busy_d  = busy_q;
    dirty_d = dirty_q;
    mru_d   = mru_q;
    if (|sel) begin
      case (op_i.kind)
        KIND_ACCESS: begin
          if (plru_enable_i) begin
            mru_d = mru_after_touch;
          end
        end
        KIND_INSERT: begin
          mru_d = mru_after_touch;
        end
        KIND_EVICT: begin
          valid_d = valid_q & ~sel;
          dirty_d = dirty_q & ~sel;
          mru_d   = mru_q & ~sel;
        end
        KIND_VALIDATE:   valid_d = valid_q | sel;
        KIND_INVALIDATE: valid_d = valid_q & ~sel;
        KIND_BUSY:       busy_d  = busy_q | sel;
        KIND_IDLE:       busy_d  = busy_q & ~sel;
        KIND_SET_DIRTY:  dirty_d = dirty_q | sel;
        default: ;
      endcase
    end
  end

  // per-way tag, sector masks and address
  always_comb begin
    tags_d    = tags_q;
    present_d = present_q;
    used_d    = used_q;
    written_d = written_q;
    addr_d    = addr_q;
    for (int i = 0; i < WAYS; i++) begin
      if (sel[i]) begin
        case (op_i.kind)
          KIND_ACCESS: begin
            used_d[i] = used_q[i] | op_i.sector_bits;
            if (op_i.is_write) begin
              written_d[i] = written_q[i] | op_i.sector_bits;
            end
          end
          KIND_INSERT: begin
            tags_d[i]    = op_i.new_tag;
            present_d[i] = op_i.sector_bits;
            used_d[i]    = '0;
            written_d[i] = '0;
            addr_d[i]    = op_i.inst_addr;
          end
          KIND_EVICT: begin
            present_d[i] = '0;
            used_d[i]    = '0;
            written_d[i] = '0;
            addr_d[i]    = '0;
          end
          KIND_INVALIDATE: begin
            present_d[i] = '0;
            used_d[i]    = '0;
            written_d[i] = '0;
          end
          KIND_ADD: begin
            present_d[i] = present_q[i] | op_i.sector_bits;
          end
          default: ;
        endcase
      end
    end
  end

  // set state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tags_q    <= '0;
      present_q <= '0;
      used_q    <= '0;
      written_q <= '0;
      addr_q    <= '0;
      valid_q   <= '0;
      busy_q    <= '0;
      dirty_q   <= '0;
      mru_q     <= '0;
    end else begin
      tags_q    <= tags_d;
      present_q <= present_d;
      used_q    <= used_d;
      written_q <= written_d;
      addr_q    <= addr_d;
      valid_q   <= valid_d;
      busy_q    <= busy_d;
      dirty_q   <= dirty_d;
      mru_q     <= mru_d;
    end
  end

  assign tags_o    = tags_q;
  assign present_o = present_q;
  assign used_o    = used_q;
  assign written_o = written_q;
  assign addr_o    = addr_q;
  assign valid_o   = valid_q;
  assign busy_o    = busy_q;
  assign dirty_o   = dirty_q;
  assign mru_o     = mru_q;

endmodule

FILE: sim/sectored_cache_set_plru_tb.sv
`timescale 1ns / 100ps

module sectored_cache_set_plru_tb;
  import scsp_pkg::*;

  localparam int POOL_SIZE      = 20;
  localparam int HOLD_AT_ITEM   = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  in_t            in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_t           out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic           cfg_data_i  = 1'b0;

  sectored_cache_set_plru uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the set state
  logic [SCSP_TAG_BITS-1:0]  way_tag     [SCSP_WAYS] = '{default: '0};
  logic [SCSP_SECTORS-1:0]   sec_present [SCSP_WAYS] = '{default: '0};
  logic [SCSP_SECTORS-1:0]   sec_used    [SCSP_WAYS] = '{default: '0};
  logic [SCSP_SECTORS-1:0]   sec_written [SCSP_WAYS] = '{default: '0};
  logic [SCSP_ADDR_BITS-1:0] way_iaddr   [SCSP_WAYS] = '{default: '0};
  logic [SCSP_WAYS-1:0]      valid_bits = '0;
  logic [SCSP_WAYS-1:0]      busy_bits  = '0;
  logic [SCSP_WAYS-1:0]      dirty_bits = '0;
  logic [SCSP_WAYS-1:0]      mru_bits   = '0;
  logic                      plru_on    = 1'b1;

  in_t  pending_ops[$];
  out_t predicted_results[$];
  out_t want_r;

  logic [SCSP_TAG_BITS-1:0] tag_pool[POOL_SIZE];

  int n_sent       = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int n_hits       = 0;
  int n_misses     = 0;
  int n_victims    = 0;
  int n_mru_wraps  = 0;
  int n_cfg_writes = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  logic hold_done  = 1'b0;
  logic in_taken   = 1'b0;

  // set the way's mru bit, wrap when all are set
  function automatic void mark_recent(input int unsigned w);
    mru_bits[w] = 1'b1;
    if (&mru_bits) begin
      mru_bits    = '0;
      mru_bits[w] = 1'b1;
      n_mru_wraps++;
    end
  endfunction

  // expected result of one set operation, updates the shadow state
  function automatic out_t predict_set_op(input in_t op);
    out_t        r;
    logic        hit;
    int unsigned w;
    r   = '0;
    hit = 1'b0;
    w   = 0;
    // first way with an equal tag, valid bit ignored
    for (int i = 0; i < SCSP_WAYS; i++) begin
      if (!hit && way_tag[i] == op.tag) begin
        hit = 1'b1;
        w   = i;
      end
    end
    r.found = hit;
    if (hit) begin
      r.block_valid       = valid_bits[w];
      r.block_busy        = busy_bits[w];
      r.block_dirty       = dirty_bits[w];
      r.sector_valid_mask = sec_present[w];
      r.used_mask         = sec_used[w];
      r.dirty_sector_mask = sec_written[w];
      r.missing_mask      = op.sector_bits & ~sec_present[w];
      r.stored_inst_addr  = way_iaddr[w];
      n_hits++;
    end else begin
      n_misses++;
    end
    // victim is the first way with a clear mru bit
    if (plru_on) begin
      for (int i = 0; i < SCSP_WAYS; i++) begin
        if (!r.victim_found && !mru_bits[i]) begin
          r.victim_found = 1'b1;
          r.victim_tag   = way_tag[i];
        end
      end
    end
    if (r.victim_found) n_victims++;
    r.free_way_exists = ~&valid_bits;

    // state update, only on a hit
    if (hit) begin
      case (op.kind)
        KIND_ACCESS: begin
          sec_used[w] |= op.sector_bits;
          if (op.is_write) sec_written[w] |= op.sector_bits;
          if (plru_on) mark_recent(w);
        end
        KIND_INSERT: begin
          way_tag[w]     = op.new_tag;
          sec_present[w] = op.sector_bits;
          sec_used[w]    = '0;
          sec_written[w] = '0;
          way_iaddr[w]   = op.inst_addr;
          mark_recent(w);
        end
        KIND_EVICT: begin
          valid_bits[w]  = 1'b0;
          dirty_bits[w]  = 1'b0;
          mru_bits[w]    = 1'b0;
          sec_present[w] = '0;
          sec_used[w]    = '0;
          sec_written[w] = '0;
          way_iaddr[w]   = '0;
        end
        KIND_VALIDATE: valid_bits[w] = 1'b1;
        KIND_INVALIDATE: begin
          valid_bits[w]  = 1'b0;
          sec_present[w] = '0;
          sec_used[w]    = '0;
          sec_written[w] = '0;
        end
        KIND_BUSY:      busy_bits[w]  = 1'b1;
        KIND_IDLE:      busy_bits[w]  = 1'b0;
        KIND_SET_DIRTY: dirty_bits[w] = 1'b1;
        KIND_ADD:       sec_present[w] |= op.sector_bits;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
    if (got !== want) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // input driver, new item only after the previous transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_data_i  <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // monitor: check results, predict accepted items, track config writes
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, out_data_o);
          n_errors++;
        end else begin
          want_r = predicted_results.pop_front();
          n_checked++;
          cmp_field("found", 64'(out_data_o.found), 64'(want_r.found));
          cmp_field("block_valid", 64'(out_data_o.block_valid),
                    64'(want_r.block_valid));
          cmp_field("block_busy", 64'(out_data_o.block_busy),
                    64'(want_r.block_busy));
          cmp_field("block_dirty", 64'(out_data_o.block_dirty),
                    64'(want_r.block_dirty));
          cmp_field("sector_valid_mask", 64'(out_data_o.sector_valid_mask),
                    64'(want_r.sector_valid_mask));
          cmp_field("used_mask", 64'(out_data_o.used_mask), 64'(want_r.used_mask));
          cmp_field("dirty_sector_mask", 64'(out_data_o.dirty_sector_mask),
                    64'(want_r.dirty_sector_mask));
          cmp_field("missing_mask", 64'(out_data_o.missing_mask),
                    64'(want_r.missing_mask));
          cmp_field("victim_found", 64'(out_data_o.victim_found),
                    64'(want_r.victim_found));
          cmp_field("victim_tag", 64'(out_data_o.victim_tag), 64'(want_r.victim_tag));
          cmp_field("free_way_exists", 64'(out_data_o.free_way_exists),
                    64'(want_r.free_way_exists));
          cmp_field("stored_inst_addr", 64'(out_data_o.stored_inst_addr),
                    64'(want_r.stored_inst_addr));
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        predicted_results.push_back(predict_set_op(in_data_i));
        n_accepted++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        plru_on = cfg_data_i;
        n_cfg_writes++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic post_op(input logic [SCSP_KIND_BITS-1:0] k,
                         input logic [SCSP_TAG_BITS-1:0] t,
                         input logic [SCSP_TAG_BITS-1:0] nt,
                         input logic [SCSP_SECTORS-1:0] sb, input logic wr,
                         input logic [SCSP_ADDR_BITS-1:0] ia);
    in_t op;
    op.kind        = k;
    op.tag         = t;
    op.new_tag     = nt;
    op.sector_bits = sb;
    op.is_write    = wr;
    op.inst_addr   = ia;
    pending_ops.push_back(op);
    n_sent++;
  endtask

  // mostly tags from a small pool so that ways get hit and replaced
  task automatic post_random_ops(input int count);
    logic [SCSP_KIND_BITS-1:0] k;
    logic [SCSP_TAG_BITS-1:0]  t;
    logic [63:0]               ia;
    logic [SCSP_SECTORS-1:0]   sb;
    logic                      wr;
    int                        roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20)      k = KIND_INSERT;
      else if (roll < 45) k = KIND_ACCESS;
      else if (roll < 52) k = KIND_LOOKUP;
      else if (roll < 58) k = KIND_EVICT;
      else if (roll < 66) k = KIND_VALIDATE;
      else if (roll < 70) k = KIND_INVALIDATE;
      else if (roll < 76) k = KIND_BUSY;
      else if (roll < 82) k = KIND_IDLE;
      else if (roll < 88) k = KIND_SET_DIRTY;
      else if (roll < 96) k = KIND_ADD;
      else                k = SCSP_KIND_BITS'($urandom_range(10, 15));
      if ($urandom_range(0, 9) == 0) t = $urandom;
      else                           t = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      ia = {$urandom, $urandom};
      sb = SCSP_SECTORS'($urandom_range(0, 255));
      wr = 1'($urandom_range(0, 1));
      post_op(k, t, tag_pool[$urandom_range(0, POOL_SIZE - 1)], sb, wr,
              ia[SCSP_ADDR_BITS-1:0]);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (n_checked != n_sent);
  endtask

  // register write only while the set is idle
  task automatic write_plru(input logic en);
    wait_drained();
    repeat (3) @(negedge clk_i);
    cfg_data_i  <= en;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = $urandom;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    send_gap_pct = 27;
    recv_gap_pct = 55;

    // directed: extremes, every operation, absent tags, busy evict and invalidate
    post_op(KIND_LOOKUP, '0, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_ACCESS, '1, '0, 8'hFF, 1'b1, '0);
    post_op(KIND_INSERT, '0, '1, 8'h3C, 1'b0, '1);
    post_op(KIND_LOOKUP, '1, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_ACCESS, '1, '0, 8'hC3, 1'b1, '0);
    post_op(KIND_ACCESS, '1, '0, 8'h3C, 1'b0, '0);
    post_op(KIND_ADD, '1, '0, 8'hC3, 1'b0, '0);
    post_op(KIND_VALIDATE, '1, '0, 8'h00, 1'b0, '0);
    post_op(KIND_BUSY, '1, '0, 8'h00, 1'b0, '0);
    post_op(KIND_SET_DIRTY, '1, '0, 8'h00, 1'b0, '0);
    post_op(KIND_INVALIDATE, '1, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_ADD, '1, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_VALIDATE, '1, '0, 8'h00, 1'b0, '0);
    post_op(KIND_EVICT, '1, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_IDLE, '1, '0, 8'h00, 1'b0, '0);
    post_op(4'd15, '1, '1, 8'hFF, 1'b1, '1);
    post_op(4'd10, '0, '0, 8'h00, 1'b0, '0);
    post_op(KIND_INSERT, 32'h1234_5678, '1, 8'hFF, 1'b1, '1);
    post_op(KIND_EVICT, 32'h0BAD_0BAD, '0, 8'hFF, 1'b0, '0);
    post_op(KIND_INSERT, '0, 32'h0000_0001, 8'h00, 1'b0, '0);
    post_op(KIND_ACCESS, 32'h0000_0001, '0, 8'h00, 1'b0, '0);

    // no replacement policy
    write_plru(1'b0);
    post_random_ops(180);

    // roles swapped, long receiver hold-off falls in this phase
    send_gap_pct = 55;
    recv_gap_pct = 27;
    write_plru(1'b1);
    post_random_ops(320);

    // back to back
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_plru(1'b0);
    post_random_ops(150);
    write_plru(1'b1);
    post_random_ops(200);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_results.size());
      n_errors++;
    end

    $display("run covered %0d set operations (%0d tag hits, %0d absent tags), %0d plru writes",
             n_checked, n_hits, n_misses, n_cfg_writes);
    $display("victims reported %0d times, mru wraps %0d, errors %0d",
             n_victims, n_mru_wraps, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/scsp_pkg.sv
rtl/core/scsp_lookup.sv
rtl/core/scsp_ways.sv
rtl/core/sectored_cache_set_plru.sv
sim/sectored_cache_set_plru_tb.sv
